[hw/rtl/assert_macros.svh]
// Assertion helpers. All of them compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/cpbc_pkg.sv]
`timescale 1ns / 1ps

package cpbc_pkg;

    localparam int MSA_LEN_DEF  = 4096;
    localparam int REF_LEN_DEF  = 4096;
    localparam int NUM_REFS_DEF = 8;

    localparam int SITE_W    = 12;
    localparam int POS_W     = 12;
    localparam int REF_SEL_W = 3;
    localparam int OFFSET_W  = 13;
    localparam int MSA_CFG_W = 13;
    localparam int COUNT_W   = 32;

    localparam logic [MSA_CFG_W-1:0] MSA_LENGTH_RST = 13'd4096;
    localparam logic [OFFSET_W-1:0]  OFFSET_MAX     = '1;

    // APB: one 32-bit register at byte address 0
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_MSA_LENGTH = 1'b0;

    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'd32;

    typedef enum logic [2:0] {
        REQ_MAP_WRITE  = 3'd0,
        REQ_READ_START = 3'd1,
        REQ_MATCH      = 3'd2,
        REQ_INSERT     = 3'd3,
        REQ_DELETION   = 3'd4,
        REQ_QUERY      = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        SLOT_A = 2'd0,
        SLOT_G = 2'd1,
        SLOT_C = 2'd2,
        SLOT_T = 2'd3
    } slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_CNT,
        S_QRY
    } state_t;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [REF_SEL_W-1:0] ref_select;
        logic [POS_W-1:0]     ref_pos;
        logic [SITE_W-1:0]    map_site;
        logic                 map_valid;
        logic [7:0]           base_char;
        logic [SITE_W-1:0]    query_site;
    } in_t;

    // also the row layout of the counter memory
    typedef struct packed {
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_g;
        logic [COUNT_W-1:0] count_c;
        logic [COUNT_W-1:0] count_t;
        logic [COUNT_W-1:0] deletion_count;
    } out_t;

    typedef struct packed {
        logic              valid;
        logic [SITE_W-1:0] site;
    } map_entry_t;

endpackage

[hw/rtl/cigar_pileup_base_counter_core.sv]
`timescale 1ns / 1ps
// channel   | signals                          | direction
// ----------+----------------------------------+-----------
// request   | req_valid, req_stall, req_data   | in
// response  | rsp_valid, rsp_stall, rsp_data   | out
// config    | APB psel/penable/pwrite/paddr... | in
//
// Map write, read start, insert/clip, unknown request: S_IDLE is not left.
// Match and deletion, when counted: map read, counter read (S_MAP), write back
// (S_CNT); a gap or unused site ends them in S_MAP; no lookup stays in S_IDLE.
// Query: counter read, then S_QRY waits for the response register to drain.
// After reset a clearing pass zeroes all MSA_LEN rows of the counter memory,
// one row per cycle; req_stall stays high meanwhile, config writes still land.

`include "assert_macros.svh"

module cigar_pileup_base_counter_core
    import cpbc_pkg::*;
#(
    parameter int MSA_LEN  = MSA_LEN_DEF,
    parameter int REF_LEN  = REF_LEN_DEF,
    parameter int NUM_REFS = NUM_REFS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_stall,
    input  in_t                   req_data,

    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output out_t                  rsp_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int MAP_DEPTH  = NUM_REFS * REF_LEN;
    localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);
    localparam int CNT_ADDR_W = $clog2(MSA_LEN);
    localparam int CMP_W      = 18;
    localparam int SUM_W      = OFFSET_W + 1;

    localparam logic [CNT_ADDR_W-1:0] CLR_LAST = CNT_ADDR_W'(MSA_LEN - 1);

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    // ---------------------------------------------------------------- state
    state_t                  state_reg, state_next;
    logic [CNT_ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [REF_SEL_W-1:0]    cur_ref_reg, cur_ref_next;
    logic [POS_W-1:0]        read_start_reg, read_start_next;
    logic [OFFSET_W-1:0]     offset_reg, offset_next;
    logic [MSA_CFG_W-1:0]    msa_length_reg, msa_length_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    item_del_reg;
    slot_t                   item_slot_reg;
    logic                    q_zero_reg;
    logic [SITE_W-1:0]       site_reg;
    out_t                    out_data_reg;

    // memories
    map_entry_t              map_mem [MAP_DEPTH];
    map_entry_t              map_rd_reg;
    out_t                    cnt_mem [MSA_LEN];
    out_t                    cnt_rd_reg;

    logic                    map_we, map_re;
    logic [MAP_ADDR_W-1:0]   map_waddr, map_raddr;
    map_entry_t              map_wdata;
    logic                    cnt_we, cnt_re;
    logic [CNT_ADDR_W-1:0]   cnt_waddr, cnt_raddr;
    out_t                    cnt_wdata;

    // ------------------------------------------------------- item decoding
    logic                    accept;
    logic [SUM_W-1:0]        pos_sum;
    logic                    pos_ok, ref_ok;
    logic                    wr_pos_ok, wr_ref_ok;
    logic [7:0]              base_up;
    logic                    slot_ok;
    slot_t                   slot;
    logic                    is_del;
    logic                    q_in_range;
    logic                    site_hit;
    logic                    out_load;
    logic                    cfg_we;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    assign pos_sum   = SUM_W'(read_start_reg) + SUM_W'(offset_reg);
    assign pos_ok    = CMP_W'(pos_sum) < CMP_W'(REF_LEN);
    assign ref_ok    = CMP_W'(cur_ref_reg) < CMP_W'(NUM_REFS);
    assign wr_pos_ok = CMP_W'(req_data.ref_pos) < CMP_W'(REF_LEN);
    assign wr_ref_ok = CMP_W'(req_data.ref_select) < CMP_W'(NUM_REFS);

    assign map_raddr = MAP_ADDR_W'(32'(cur_ref_reg) * 32'(REF_LEN) + 32'(pos_sum));
    assign map_waddr = MAP_ADDR_W'(32'(req_data.ref_select) * 32'(REF_LEN)
                                   + 32'(req_data.ref_pos));
    assign map_wdata = '{valid: req_data.map_valid, site: req_data.map_site};

    assign base_up = (req_data.base_char >= CH_LOWER_A && req_data.base_char <= CH_LOWER_Z)
                   ? req_data.base_char - CASE_FOLD : req_data.base_char;

    always_comb
    begin
        slot    = SLOT_A;
        slot_ok = 1'b1;
        priority if (base_up == CH_A)
            slot = SLOT_A;
        else if (base_up == CH_G)
            slot = SLOT_G;
        else if (base_up == CH_C)
            slot = SLOT_C;
        else if (base_up == CH_T)
            slot = SLOT_T;
        else
            slot_ok = 1'b0;
    end

    assign is_del     = (req_data.req_type == REQ_DELETION);
    assign q_in_range = CMP_W'(req_data.query_site) < CMP_W'(MSA_LEN);

    // map entry returned in S_MAP
    assign site_hit = map_rd_reg.valid
                   && (MSA_CFG_W'(map_rd_reg.site) < msa_length_reg)
                   && (CMP_W'(map_rd_reg.site) < CMP_W'(MSA_LEN));

    // ------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite
                 && (paddr[APB_ADDR_W-1:2] == REG_MSA_LENGTH);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_MSA_LENGTH)
                  ? APB_DATA_W'(msa_length_reg) : '0;

    // ------------------------------------------------------ control logic
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_ref_next    = cur_ref_reg;
        read_start_next = read_start_reg;
        offset_next     = offset_reg;
        msa_length_next = cfg_we ? pwdata[MSA_CFG_W-1:0] : msa_length_reg;
        map_we          = 1'b0;
        map_re          = 1'b0;
        cnt_we          = 1'b0;
        cnt_re          = 1'b0;
        cnt_waddr       = CNT_ADDR_W'(site_reg);
        cnt_raddr       = CNT_ADDR_W'(req_data.query_site);
        cnt_wdata       = cnt_rd_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_addr_reg;
                cnt_wdata = '0;
                if (clr_addr_reg == CLR_LAST)
                    state_next = S_IDLE;
                else
                    clr_addr_next = clr_addr_reg + CNT_ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_t'(req_data.req_type))
                        REQ_MAP_WRITE:
                            map_we = wr_ref_ok && wr_pos_ok;
                        REQ_READ_START:
                        begin
                            cur_ref_next    = req_data.ref_select;
                            read_start_next = req_data.ref_pos;
                            offset_next     = '0;
                        end
                        REQ_MATCH, REQ_DELETION:
                        begin
                            if (offset_reg != OFFSET_MAX)
                                offset_next = offset_reg + OFFSET_W'(1);
                            if (ref_ok && pos_ok && (is_del || slot_ok))
                            begin
                                map_re     = 1'b1;
                                state_next = S_MAP;
                            end
                        end
                        REQ_INSERT:
                        begin
                        end
                        REQ_QUERY:
                        begin
                            cnt_re     = q_in_range;
                            state_next = S_QRY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MAP:
            begin
                cnt_raddr = CNT_ADDR_W'(CMP_W'(map_rd_reg.site));
                if (site_hit)
                begin
                    cnt_re     = 1'b1;
                    state_next = S_CNT;
                end
                else
                    state_next = S_IDLE;
            end
            S_CNT:
            begin
                cnt_we = 1'b1;
                if (item_del_reg)
                    cnt_wdata.deletion_count = sat_inc(cnt_rd_reg.deletion_count);
                else
                begin
                    unique case (item_slot_reg)
                        SLOT_A: cnt_wdata.count_a = sat_inc(cnt_rd_reg.count_a);
                        SLOT_G: cnt_wdata.count_g = sat_inc(cnt_rd_reg.count_g);
                        SLOT_C: cnt_wdata.count_c = sat_inc(cnt_rd_reg.count_c);
                        SLOT_T: cnt_wdata.count_t = sat_inc(cnt_rd_reg.count_t);
                        default: cnt_wdata = cnt_rd_reg;
                    endcase
                end
                state_next = S_IDLE;
            end
            S_QRY:
            begin
                // counter read data holds until the response register frees up
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            cur_ref_reg    <= '0;
            read_start_reg <= '0;
            offset_reg     <= '0;
            msa_length_reg <= MSA_LENGTH_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cur_ref_reg    <= cur_ref_next;
            read_start_reg <= read_start_next;
            offset_reg     <= offset_next;
            msa_length_reg <= msa_length_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_del_reg  <= is_del;
            item_slot_reg <= slot;
            q_zero_reg    <= !q_in_range;
        end
        if (state_reg == S_MAP)
            site_reg <= map_rd_reg.site;
        if (out_load)
            out_data_reg <= q_zero_reg ? '0 : cnt_rd_reg;
    end

    // ----------------------------------------------------------- memories
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (map_re)
            map_rd_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // --------------------------------------------------------- assertions
    `ASSERT_IMPL(a_clear_no_rsp, clk, rst_n, state_reg == S_CLEAR, !out_valid_reg)
    `ASSERT_IMPL(a_cnt_after_map, clk, rst_n, state_reg == S_CNT, $past(state_reg) == S_MAP)
    `ASSERT_IMPL(a_cnt_no_wrap, clk, rst_n, state_reg == S_CNT,
        cnt_wdata.deletion_count >= cnt_rd_reg.deletion_count
        && cnt_wdata.count_a >= cnt_rd_reg.count_a
        && cnt_wdata.count_t >= cnt_rd_reg.count_t)
    `ASSERT_NEXT(a_offset_sat, clk, rst_n,
        accept && (req_data.req_type == REQ_MATCH || req_data.req_type == REQ_DELETION)
        && offset_reg == OFFSET_MAX, offset_reg == OFFSET_MAX)

endmodule
